>>> src/ldpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldpl_pkg
// Shared types, widths and helpers for the diffuse polygon lighting block.
// ----------------------------------------------------------------------------
package ldpl_pkg;

    localparam int VECTOR_WIDTH = 16;
    localparam int ACCUM_WIDTH  = 12;
    localparam int VEC_SHIFT    = (VECTOR_WIDTH > 16) ? (VECTOR_WIDTH - 16) : 0;
    localparam int ADDR_W       = 5;
    localparam int SQRT_STAGES  = 32;
    localparam int DIV_STAGES   = 15;
    localparam int DOT_FRAC     = 14;
    localparam int LIT_SHIFT    = 22;

    typedef enum logic [2:0] {
        REG_LIGHT_RED   = 3'd0,
        REG_LIGHT_GREEN = 3'd1,
        REG_LIGHT_BLUE  = 3'd2,
        REG_LIGHT_ALPHA = 3'd3,
        REG_DIR_X       = 3'd4,
        REG_DIR_Y       = 3'd5,
        REG_DIR_Z       = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic                           back_facing;
        logic signed [VECTOR_WIDTH-1:0] normal_x;
        logic signed [VECTOR_WIDTH-1:0] normal_y;
        logic signed [VECTOR_WIDTH-1:0] normal_z;
        logic [8:0]                     refl_red;
        logic [8:0]                     refl_green;
        logic [8:0]                     refl_blue;
        logic [ACCUM_WIDTH-1:0]         acc_alpha;
        logic [ACCUM_WIDTH-1:0]         acc_red;
        logic [ACCUM_WIDTH-1:0]         acc_green;
        logic [ACCUM_WIDTH-1:0]         acc_blue;
    } in_item_t;

    typedef struct packed {
        logic [ACCUM_WIDTH-1:0] lit_alpha;
        logic [ACCUM_WIDTH-1:0] lit_red;
        logic [ACCUM_WIDTH-1:0] lit_green;
        logic [ACCUM_WIDTH-1:0] lit_blue;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         light_red;
        logic [7:0]         light_green;
        logic [7:0]         light_blue;
        logic [7:0]         light_alpha;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } cfg_t;

    typedef struct packed {
        logic                   back;
        logic                   neg;
        logic                   dz;
        logic [31:0]            mag;
        logic [16:0]            lr_red;
        logic [16:0]            lr_green;
        logic [16:0]            lr_blue;
        logic [ACCUM_WIDTH-1:0] acc_alpha;
        logic [ACCUM_WIDTH-1:0] acc_red;
        logic [ACCUM_WIDTH-1:0] acc_green;
        logic [ACCUM_WIDTH-1:0] acc_blue;
    } side_t;

    // Wide components keep their sign and lose low magnitude bits.
    function automatic logic signed [15:0] vec_to_eff(input logic [VECTOR_WIDTH-1:0] v);
        logic signed [32:0] s;
        logic [32:0]        m;
        s = 33'(signed'(v));
        m = (s < 0) ? 33'(-s) : 33'(s);
        m = m >> VEC_SHIFT;
        return (s < 0) ? -16'(m) : 16'(m);
    endfunction

endpackage
`default_nettype wire

>>> src/ldpl_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldpl_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module ldpl_regs import ldpl_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            case (idx)
                REG_LIGHT_RED:   cfg_next.light_red   = pwdata[7:0];
                REG_LIGHT_GREEN: cfg_next.light_green = pwdata[7:0];
                REG_LIGHT_BLUE:  cfg_next.light_blue  = pwdata[7:0];
                REG_LIGHT_ALPHA: cfg_next.light_alpha = pwdata[7:0];
                REG_DIR_X:       cfg_next.dir_x = vec_to_eff(pwdata[VECTOR_WIDTH-1:0]);
                REG_DIR_Y:       cfg_next.dir_y = vec_to_eff(pwdata[VECTOR_WIDTH-1:0]);
                REG_DIR_Z:       cfg_next.dir_z = vec_to_eff(pwdata[VECTOR_WIDTH-1:0]);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LIGHT_RED:   prdata = 32'(cfg_reg.light_red);
            REG_LIGHT_GREEN: prdata = 32'(cfg_reg.light_green);
            REG_LIGHT_BLUE:  prdata = 32'(cfg_reg.light_blue);
            REG_LIGHT_ALPHA: prdata = 32'(cfg_reg.light_alpha);
            REG_DIR_X:       prdata = 32'(cfg_reg.dir_x);
            REG_DIR_Y:       prdata = 32'(cfg_reg.dir_y);
            REG_DIR_Z:       prdata = 32'(cfg_reg.dir_z);
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

>>> src/ldpl_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldpl_sqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module ldpl_sqrt import ldpl_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [63:0] in_x,
    input  wire side_t       in_side,
    output logic             out_valid,
    output logic [31:0]      out_root,
    output side_t            out_side
);

    logic [63:0] x_cur  [SQRT_STAGES];
    logic [63:0] r_cur  [SQRT_STAGES];
    logic        v_cur  [SQRT_STAGES];
    side_t       s_cur  [SQRT_STAGES];
    logic [63:0] x_next [SQRT_STAGES];
    logic [63:0] r_next [SQRT_STAGES];
    logic [63:0] x_reg  [SQRT_STAGES];
    logic [63:0] r_reg  [SQRT_STAGES];
    logic        v_reg  [SQRT_STAGES];
    side_t       s_reg  [SQRT_STAGES];

    assign x_cur[0] = in_x;
    assign r_cur[0] = 64'd0;
    assign v_cur[0] = in_valid;
    assign s_cur[0] = in_side;

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        if (k > 0) begin : g_link
            assign x_cur[k] = x_reg[k-1];
            assign r_cur[k] = r_reg[k-1];
            assign v_cur[k] = v_reg[k-1];
            assign s_cur[k] = s_reg[k-1];
        end
        always_comb begin
            if (x_cur[k] >= r_cur[k] + BIT) begin
                x_next[k] = x_cur[k] - (r_cur[k] + BIT);
                r_next[k] = (r_cur[k] >> 1) + BIT;
            end else begin
                x_next[k] = x_cur[k];
                r_next[k] = r_cur[k] >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_cur[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k] <= x_next[k];
                r_reg[k] <= r_next[k];
                s_reg[k] <= s_cur[k];
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_root  = r_reg[SQRT_STAGES-1][31:0];
    assign out_side  = s_reg[SQRT_STAGES-1];

endmodule
`default_nettype wire

>>> src/ldpl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldpl_div
// Pipelined restoring divider for the Q1.14 dot, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ldpl_div import ldpl_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [31:0]           in_den,
    input  wire side_t                 in_side,
    output logic                       out_valid,
    output logic [DIV_STAGES-1:0]      out_q,
    output side_t                      out_side
);

    localparam int RW = 32 + DOT_FRAC;

    logic [RW-1:0]         rem_cur  [DIV_STAGES];
    logic [31:0]           den_cur  [DIV_STAGES];
    logic [DIV_STAGES-1:0] q_cur    [DIV_STAGES];
    logic                  v_cur    [DIV_STAGES];
    side_t                 s_cur    [DIV_STAGES];
    logic [RW-1:0]         rem_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] q_next   [DIV_STAGES];
    logic [RW-1:0]         rem_reg  [DIV_STAGES];
    logic [31:0]           den_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] q_reg    [DIV_STAGES];
    logic                  v_reg    [DIV_STAGES];
    side_t                 s_reg    [DIV_STAGES];

    assign rem_cur[0] = RW'(in_side.mag) << DOT_FRAC;
    assign den_cur[0] = in_den;
    assign q_cur[0]   = '0;
    assign v_cur[0]   = in_valid;
    assign s_cur[0]   = in_side;

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        localparam int SH = DIV_STAGES - 1 - i;
        logic [RW-1:0] dsh;
        if (i > 0) begin : g_link
            assign rem_cur[i] = rem_reg[i-1];
            assign den_cur[i] = den_reg[i-1];
            assign q_cur[i]   = q_reg[i-1];
            assign v_cur[i]   = v_reg[i-1];
            assign s_cur[i]   = s_reg[i-1];
        end
        assign dsh = RW'(den_cur[i]) << SH;
        always_comb begin
            rem_next[i] = rem_cur[i];
            q_next[i]   = q_cur[i];
            if (rem_cur[i] >= dsh) begin
                rem_next[i]  = rem_cur[i] - dsh;
                q_next[i][SH] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_cur[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_cur[i];
                q_reg[i]   <= q_next[i];
                s_reg[i]   <= s_cur[i];
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_q     = q_reg[DIV_STAGES-1];
    assign out_side  = s_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

>>> src/lambert_diffuse_polygon_light.sv
`default_nettype none
// Throughput: one item per cycle while the result side is not stalled;
// a 32-stage square root and a 15-stage divider, each one bit per stage,
// set the depth of the pipeline.
// A stall on the result side holds every stage in place.
// Reset is synchronous and active low; it clears the valid bits and all
// configuration registers to zero.
// ----------------------------------------------------------------------------
// lambert_diffuse_polygon_light
// Lambertian diffuse lighting of one polygon by one directional light.
// ----------------------------------------------------------------------------
module lambert_diffuse_polygon_light import ldpl_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_item
);

    cfg_t cfg;
    logic en;

    ldpl_regs u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage 0: capture and scale components.
    logic               v0_reg;
    in_item_t           it0_reg;
    logic signed [15:0] n0_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it0_reg   <= s_item;
            n0_reg[0] <= vec_to_eff(s_item.normal_x);
            n0_reg[1] <= vec_to_eff(s_item.normal_y);
            n0_reg[2] <= vec_to_eff(s_item.normal_z);
        end
    end

    // Stage 1: products.
    logic               v1_reg;
    in_item_t           it1_reg;
    logic signed [31:0] nd1_reg [3];
    logic [31:0]        nn1_reg [3];
    logic [31:0]        dd1_reg [3];
    logic [16:0]        lr1_reg [3];
    logic signed [15:0] dir [3];

    assign dir[0] = cfg.dir_x;
    assign dir[1] = cfg.dir_y;
    assign dir[2] = cfg.dir_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it1_reg <= it0_reg;
            for (int i = 0; i < 3; i++) begin
                nd1_reg[i] <= n0_reg[i] * dir[i];
                nn1_reg[i] <= 32'(n0_reg[i] * n0_reg[i]);
                dd1_reg[i] <= 32'(dir[i] * dir[i]);
            end
            lr1_reg[0] <= cfg.light_red   * it0_reg.refl_red;
            lr1_reg[1] <= cfg.light_green * it0_reg.refl_green;
            lr1_reg[2] <= cfg.light_blue  * it0_reg.refl_blue;
        end
    end

    // Stage 2: sums.
    logic               v2_reg;
    in_item_t           it2_reg;
    logic signed [33:0] num2_reg;
    logic [31:0]        ln2_reg, ld2_reg;
    logic [16:0]        lr2_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it2_reg  <= it1_reg;
            num2_reg <= 34'(nd1_reg[0]) + 34'(nd1_reg[1]) + 34'(nd1_reg[2]);
            ln2_reg  <= nn1_reg[0] + nn1_reg[1] + nn1_reg[2];
            ld2_reg  <= dd1_reg[0] + dd1_reg[1] + dd1_reg[2];
            lr2_reg  <= lr1_reg;
        end
    end

    // Stage 3: radicand and magnitude of the numerator.
    logic        v3_reg;
    logic [63:0] x3_reg;
    side_t       side3_reg;
    logic [33:0] mag2;

    assign mag2 = (num2_reg < 0) ? 34'(-num2_reg) : 34'(num2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x3_reg              <= ln2_reg * ld2_reg;
            side3_reg.back      <= it2_reg.back_facing;
            side3_reg.neg       <= num2_reg < 0;
            side3_reg.dz        <= 1'b0;
            side3_reg.mag       <= mag2[31:0];
            side3_reg.lr_red    <= lr2_reg[0];
            side3_reg.lr_green  <= lr2_reg[1];
            side3_reg.lr_blue   <= lr2_reg[2];
            side3_reg.acc_alpha <= it2_reg.acc_alpha;
            side3_reg.acc_red   <= it2_reg.acc_red;
            side3_reg.acc_green <= it2_reg.acc_green;
            side3_reg.acc_blue  <= it2_reg.acc_blue;
        end
    end

    logic        sq_valid;
    logic [31:0] sq_root;
    side_t       sq_side, dv_in_side;

    ldpl_sqrt u_sqrt (
        .aclk, .aresetn, .en,
        .in_valid (v3_reg),
        .in_x     (x3_reg),
        .in_side  (side3_reg),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    always_comb begin
        dv_in_side    = sq_side;
        dv_in_side.dz = (sq_root == 32'd0);
    end

    logic                  dv_valid;
    logic [DIV_STAGES-1:0] dv_q;
    side_t                 dv_side;

    ldpl_div u_div (
        .aclk, .aresetn, .en,
        .in_valid (sq_valid),
        .in_den   (sq_root),
        .in_side  (dv_in_side),
        .out_valid(dv_valid),
        .out_q    (dv_q),
        .out_side (dv_side)
    );

    // Lit channels.
    logic                   vl_reg;
    logic                   backl_reg;
    logic [ACCUM_WIDTH-1:0] accl_reg [4];
    logic [7:0]             lit_reg  [3];
    logic [7:0]             alpha_add;
    logic                   dot_pos;
    logic [31:0]            prod     [3];
    logic [7:0]             lit_next [3];

    assign dot_pos   = !dv_side.neg && !dv_side.dz && (dv_q != '0);
    assign alpha_add = cfg.light_alpha;
    assign prod[0]   = dv_side.lr_red   * dv_q;
    assign prod[1]   = dv_side.lr_green * dv_q;
    assign prod[2]   = dv_side.lr_blue  * dv_q;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!dot_pos) begin
                lit_next[i] = 8'd0;
            end else if ((prod[i] >> LIT_SHIFT) > 32'd255) begin
                lit_next[i] = 8'd255;
            end else begin
                lit_next[i] = prod[i][LIT_SHIFT+7:LIT_SHIFT];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg <= 1'b0;
        end else if (en) begin
            vl_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            backl_reg   <= dv_side.back;
            accl_reg[0] <= dv_side.acc_alpha;
            accl_reg[1] <= dv_side.acc_red;
            accl_reg[2] <= dv_side.acc_green;
            accl_reg[3] <= dv_side.acc_blue;
            lit_reg     <= lit_next;
        end
    end

    // Output stage: saturating accumulate.
    logic                   m_valid_reg;
    out_item_t              m_item_reg;
    logic [ACCUM_WIDTH-1:0] sum_sat [4];
    logic [7:0]             addend  [4];
    logic [ACCUM_WIDTH:0]   sum     [4];

    assign addend[0] = alpha_add;
    assign addend[1] = lit_reg[0];
    assign addend[2] = lit_reg[1];
    assign addend[3] = lit_reg[2];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sum[i] = (ACCUM_WIDTH+1)'(accl_reg[i]) + (ACCUM_WIDTH+1)'(addend[i]);
            if (backl_reg) begin
                sum_sat[i] = accl_reg[i];
            end else if (sum[i][ACCUM_WIDTH]) begin
                sum_sat[i] = '1;
            end else begin
                sum_sat[i] = sum[i][ACCUM_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_item_reg.lit_alpha <= sum_sat[0];
            m_item_reg.lit_red   <= sum_sat[1];
            m_item_reg.lit_green <= sum_sat[2];
            m_item_reg.lit_blue  <= sum_sat[3];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef NO_ASSERTIONS
    a_accept_enters : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v0_reg)
        else $error("accepted item did not enter the pipeline");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(v0_reg) && $stable(vl_reg) && $stable(dv_valid))
        else $error("pipeline advanced during a stall");

    a_no_light_no_lit : assert property (@(posedge aclk) disable iff (!aresetn)
        en && dv_valid && (dv_side.dz || dv_side.neg) |=> lit_reg[0] == 8'd0 &&
        lit_reg[1] == 8'd0 && lit_reg[2] == 8'd0)
        else $error("lit channel nonzero for a non-positive dot");
`endif

endmodule
`default_nettype wire

>>> bench/tb_lambert_diffuse_polygon_light.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lambert_diffuse_polygon_light
// Drives polygons through the diffuse lighting block under several light
// settings, predicts every lit colour in the bench and compares each result
// item with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_lambert_diffuse_polygon_light;
    import ldpl_pkg::*;

    localparam int LATENCY = 53;
    localparam longint CYCLE_LIMIT = 400000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_item = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_item;

    logic [7:0]         lt_red, lt_green, lt_blue, lt_alpha;
    logic signed [15:0] lt_dir [3];
    out_item_t          colour_queue [$];
    int                 errors = 0;
    longint             cycles = 0;
    bit                 send_idle = 1'b1;
    bit                 recv_idle = 1'b1;
    int                 hold_off = 0;

    lambert_diffuse_polygon_light dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [ACCUM_WIDTH-1:0] sat_sum(logic [ACCUM_WIDTH-1:0] a,
                                                       longint b);
        longint s;
        s = longint'(a) + b;
        return (s > 4095) ? 12'd4095 : s[11:0];
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint shade(logic [7:0] light, logic [8:0] refl, longint dot);
        longint v;
        if (dot <= 0) return 0;
        v = (longint'(light) * longint'(refl) * dot) >>> 22;
        return (v > 255) ? 255 : v;
    endfunction

    function automatic out_item_t light_polygon(in_item_t p);
        out_item_t o;
        longint n [3];
        longint num, dot, mag, q;
        longint unsigned ln, ld, den;
        if (p.back_facing) begin
            o.lit_alpha = p.acc_alpha;
            o.lit_red = p.acc_red;
            o.lit_green = p.acc_green;
            o.lit_blue = p.acc_blue;
            return o;
        end
        n[0] = p.normal_x;
        n[1] = p.normal_y;
        n[2] = p.normal_z;
        num = 0;
        ln = 0;
        ld = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            num += n[i] * longint'(lt_dir[i]);
            ln += n[i] * n[i];
            ld += longint'(lt_dir[i]) * longint'(lt_dir[i]);
        end
        den = int_sqrt(ln * ld);
        if (den != 0) begin
            mag = (num < 0) ? -num : num;
            q = longint'((unsigned'(mag) << 14) / den);
            if (q > 16384) q = 16384;
            dot = (num < 0) ? -q : q;
        end
        o.lit_alpha = sat_sum(p.acc_alpha, lt_alpha);
        o.lit_red = sat_sum(p.acc_red, shade(lt_red, p.refl_red, dot));
        o.lit_green = sat_sum(p.acc_green, shade(lt_green, p.refl_green, dot));
        o.lit_blue = sat_sum(p.acc_blue, shade(lt_blue, p.refl_blue, dot));
        return o;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LIGHT_RED:   lt_red = value[7:0];
            REG_LIGHT_GREEN: lt_green = value[7:0];
            REG_LIGHT_BLUE:  lt_blue = value[7:0];
            REG_LIGHT_ALPHA: lt_alpha = value[7:0];
            REG_DIR_X:       lt_dir[0] = value[15:0];
            REG_DIR_Y:       lt_dir[1] = value[15:0];
            default:         lt_dir[2] = value[15:0];
        endcase
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (colour_queue.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic set_light(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                             logic [15:0] x, logic [15:0] y, logic [15:0] z);
        drain();
        write_reg(REG_LIGHT_RED, 32'(r));
        write_reg(REG_LIGHT_GREEN, 32'(g));
        write_reg(REG_LIGHT_BLUE, 32'(b));
        write_reg(REG_LIGHT_ALPHA, 32'(a));
        write_reg(REG_DIR_X, {16'd0, x});
        write_reg(REG_DIR_Y, {16'd0, y});
        write_reg(REG_DIR_Z, {16'd0, z});
    endtask

    // The item stays offered after acceptance until the next item or an idle
    // stretch replaces it; drain withdraws it.
    task automatic send_polygon(in_item_t p);
        if (send_idle && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_item <= p;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        colour_queue.push_back(light_polygon(p));
    endtask

    function automatic in_item_t random_polygon();
        in_item_t p;
        p = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
        p.back_facing = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 3) == 0) p.normal_x = 16'($signed($urandom_range(0, 6)) - 3);
        if ($urandom_range(0, 3) == 0) p.normal_y = 16'($signed($urandom_range(0, 6)) - 3);
        if ($urandom_range(0, 9) == 0) begin
            p.normal_x = '0;
            p.normal_y = '0;
            p.normal_z = '0;
        end
        if ($urandom_range(0, 2) != 0) begin
            p.refl_red = 9'($urandom_range(0, 256));
            p.refl_green = 9'($urandom_range(0, 256));
            p.refl_blue = 9'($urandom_range(0, 256));
        end
        return p;
    endfunction

    // Receiver: random stalls plus one long hold-off requested by the stimulus.
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (recv_idle) begin
            m_ready <= ($urandom_range(0, 5) != 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (colour_queue.size() == 0) begin
                $error("result item with no prediction waiting");
                errors++;
            end else begin
                e = colour_queue.pop_front();
                if (m_item.lit_alpha !== e.lit_alpha) begin
                    $error("lit_alpha expected %0d got %0d", e.lit_alpha, m_item.lit_alpha);
                    errors++;
                end
                if (m_item.lit_red !== e.lit_red) begin
                    $error("lit_red expected %0d got %0d", e.lit_red, m_item.lit_red);
                    errors++;
                end
                if (m_item.lit_green !== e.lit_green) begin
                    $error("lit_green expected %0d got %0d", e.lit_green, m_item.lit_green);
                    errors++;
                end
                if (m_item.lit_blue !== e.lit_blue) begin
                    $error("lit_blue expected %0d got %0d", e.lit_blue, m_item.lit_blue);
                    errors++;
                end
            end
        end
    end

    task automatic test_reset_light;
        in_item_t p;
        p = random_polygon();
        p.back_facing = 1'b0;
        send_polygon(p);
    endtask

    task automatic test_directed;
        in_item_t p;
        set_light(8'd255, 8'd255, 8'd255, 8'd255, 16'h7fff, 16'h8000, 16'h0001);
        p = '0;
        send_polygon(p);
        p.normal_x = 16'h7fff;
        p.normal_y = 16'h8000;
        p.normal_z = 16'h0001;
        p.refl_red = 9'd256;
        p.refl_green = 9'd511;
        p.refl_blue = 9'd0;
        send_polygon(p);
        p.acc_alpha = 12'hfff;
        p.acc_red = 12'hfff;
        p.acc_green = 12'hf80;
        p.acc_blue = 12'hfff;
        send_polygon(p);
        p.normal_x = 16'h8001;
        p.normal_y = 16'h7fff;
        send_polygon(p);
        p.back_facing = 1'b1;
        send_polygon(p);
        p = '1;
        send_polygon(p);
        p.back_facing = 1'b0;
        send_polygon(p);
        set_light(8'd200, 8'd100, 8'd50, 8'd7, 16'd0, 16'd0, 16'd0);
        p.normal_x = 16'd5;
        p.normal_y = 16'd3;
        p.normal_z = 16'd1;
        send_polygon(p);
        set_light(8'd255, 8'd128, 8'd1, 8'd0, 16'd0, 16'd0, 16'd1);
        for (int i = 0; i < 6; i++) begin
            p = '0;
            p.normal_z = (i < 3) ? 16'sd1000 : -16'sd1000;
            p.normal_x = 16'(i * 300);
            p.refl_red = 9'd256;
            p.refl_green = 9'd300;
            p.refl_blue = 9'd128;
            send_polygon(p);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_polygon(random_polygon());
    endtask

    task automatic test_backpressure;
        drain();
        hold_off = 300;
        test_random(150);
    endtask

    task automatic test_settings;
        for (int s = 0; s < 4; s++) begin
            set_light(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
            test_random(350);
        end
        set_light(8'd0, 8'd0, 8'd0, 8'd0, 16'h8000, 16'h8000, 16'h8000);
        test_random(100);
    endtask

    task automatic test_no_idle;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        set_light(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
        test_random(250);
    endtask

    initial begin
        lt_red = 0;
        lt_green = 0;
        lt_blue = 0;
        lt_alpha = 0;
        lt_dir[0] = 0;
        lt_dir[1] = 0;
        lt_dir[2] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_light();
        test_directed();
        test_backpressure();
        test_settings();
        test_no_idle();
        drain();
        if (errors == 0 && colour_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
